>>> src/ecr_pkg.sv
// Package for the embedded controller register file.
// Holds widths, command codes, register indexes, reset values and the sensor tables.
// Used by ecr_cfg and embedded_controller_regs; it depends on nothing.
package ecr_pkg;

  localparam int RAM_DEPTH = 256;
  localparam int ADDR_W = $clog2(RAM_DEPTH);
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [63:0] REFRESH_PERIOD_NS = 64'd500000000;
  localparam int NOISE_LSB = 27;
  localparam logic [15:0] FAN_NOISE_STEP = 16'd50;
  localparam logic [15:0] BATTERY_VOLTAGE_MV = 16'd1140;

  localparam logic [1:0] CMD_DATA_READ = 2'd0;
  localparam logic [1:0] CMD_DATA_WRITE = 2'd1;
  localparam logic [1:0] CMD_STATUS_READ = 2'd2;
  localparam logic [1:0] CMD_COMMAND_WRITE = 2'd3;

  localparam logic [7:0] OPC_RD_ARM = 8'h80;
  localparam logic [7:0] OPC_WR_ARM = 8'h81;

  localparam logic [CFG_INDEX_W-1:0] CFG_CPU_TEMPERATURE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GPU_TEMPERATURE = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAN_SPEED = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BATTERY_PERCENT = 8'd3;

  localparam logic [7:0] RST_CPU_TEMPERATURE = 8'd65;
  localparam logic [7:0] RST_GPU_TEMPERATURE = 8'd70;
  localparam logic [15:0] RST_FAN_SPEED = 16'd2200;
  localparam logic [7:0] RST_BATTERY_PERCENT = 8'd87;
  localparam logic [7:0] RST_BACKLIGHT = 8'd100;

  localparam logic [7:0] REG_CPU_TEMP = 8'h07;
  localparam logic [7:0] REG_GPU_TEMP = 8'h0B;
  localparam logic [7:0] REG_FAN_LO = 8'h0E;
  localparam logic [7:0] REG_FAN_HI = 8'h0F;
  localparam logic [7:0] REG_BATTERY = 8'h2C;
  localparam logic [7:0] REG_VOLTAGE_LO = 8'h2E;
  localparam logic [7:0] REG_VOLTAGE_HI = 8'h2F;
  localparam logic [7:0] REG_AC = 8'h42;
  localparam logic [7:0] REG_LID = 8'h46;
  localparam logic [7:0] REG_BACKLIGHT = 8'h5A;
  localparam logic [7:0] REG_VERSION = 8'hFE;
  localparam logic [7:0] REG_STATUS = 8'hFF;
  localparam logic [7:0] VERSION_CODE = 8'h42;

  localparam int REFRESH_STEPS = 11;
  localparam int STEP_W = $clog2(REFRESH_STEPS);

  typedef struct packed {
    logic [7:0] cpu_temperature;
    logic [7:0] gpu_temperature;
    logic [15:0] fan_speed;
    logic [7:0] battery_percent;
  } ecr_cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0] data;
  } ecr_wr_t;

  function automatic logic [7:0] reset_byte(input logic [ADDR_W-1:0] addr);
    logic [7:0] value;
    value = 8'd0;
    case (addr)
      REG_CPU_TEMP: value = RST_CPU_TEMPERATURE;
      REG_GPU_TEMP: value = RST_GPU_TEMPERATURE;
      REG_FAN_LO: value = RST_FAN_SPEED[7:0];
      REG_FAN_HI: value = RST_FAN_SPEED[15:8];
      REG_BATTERY: value = RST_BATTERY_PERCENT;
      REG_AC: value = 8'd1;
      REG_LID: value = 8'd1;
      REG_BACKLIGHT: value = RST_BACKLIGHT;
      REG_VERSION: value = VERSION_CODE;
      default: value = 8'd0;
    endcase
    return value;
  endfunction

  function automatic ecr_wr_t refresh_entry(input logic [STEP_W-1:0] step,
                                            input ecr_cfg_t cfg,
                                            input logic [1:0] noise);
    ecr_wr_t entry;
    logic [15:0] rpm;
    rpm = cfg.fan_speed + 16'(FAN_NOISE_STEP * 16'(noise));
    entry.addr = REG_STATUS;
    entry.data = 8'd0;
    case (step)
      4'd0: begin
        entry.addr = REG_CPU_TEMP;
        entry.data = cfg.cpu_temperature + 8'(noise);
      end
      4'd1: begin
        entry.addr = REG_GPU_TEMP;
        entry.data = cfg.gpu_temperature + 8'(noise[1]);
      end
      4'd2: begin
        entry.addr = REG_FAN_LO;
        entry.data = rpm[7:0];
      end
      4'd3: begin
        entry.addr = REG_FAN_HI;
        entry.data = rpm[15:8];
      end
      4'd4: begin
        entry.addr = REG_BATTERY;
        entry.data = cfg.battery_percent;
      end
      4'd5: begin
        entry.addr = REG_AC;
        entry.data = 8'd1;
      end
      4'd6: begin
        entry.addr = REG_LID;
        entry.data = 8'd1;
      end
      4'd7: begin
        entry.addr = REG_VERSION;
        entry.data = VERSION_CODE;
      end
      4'd8: begin
        entry.addr = REG_STATUS;
        entry.data = 8'd0;
      end
      4'd9: begin
        entry.addr = REG_VOLTAGE_LO;
        entry.data = BATTERY_VOLTAGE_MV[7:0];
      end
      4'd10: begin
        entry.addr = REG_VOLTAGE_HI;
        entry.data = BATTERY_VOLTAGE_MV[15:8];
      end
      default: begin
        entry.addr = REG_STATUS;
        entry.data = 8'd0;
      end
    endcase
    return entry;
  endfunction

endpackage

>>> src/ecr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; width and depth come from its parameters.
module ecr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/ecr_cfg.sv
// Configuration register bank of the embedded controller register file.
// Depends on ecr_pkg for register indexes, reset values and the ecr_cfg_t struct.
module ecr_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ecr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ecr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ecr_pkg::ecr_cfg_t                  cfg
);
  import ecr_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cpu_temperature <= RST_CPU_TEMPERATURE;
      cfg.gpu_temperature <= RST_GPU_TEMPERATURE;
      cfg.fan_speed <= RST_FAN_SPEED;
      cfg.battery_percent <= RST_BATTERY_PERCENT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CPU_TEMPERATURE: cfg.cpu_temperature <= cfg_data[7:0];
        CFG_GPU_TEMPERATURE: cfg.gpu_temperature <= cfg_data[7:0];
        CFG_FAN_SPEED: cfg.fan_speed <= cfg_data;
        CFG_BATTERY_PERCENT: cfg.battery_percent <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/embedded_controller_regs.sv
// Top level of the embedded controller register file: command port, sequencer and RAM.
// Depends on ecr_pkg, ecr_cfg and ecr_ram.
//
// After reset the block fills the register RAM with its default bytes, with busy high.
// A data write or command write is taken in S_IDLE without raising busy. A data read
// or status read returns its byte on read_data with read_valid high for one cycle,
// after S_CHECK, or after S_CHECK, S_REFRESH and S_READ when the sensor bytes are due
// for a refresh, since the eleven sensor bytes go one per cycle through the RAM
// write port. The result cannot be held off; busy stays high until it has been shown.
module embedded_controller_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      cmd,
  input  logic [7:0]                      data_value,
  input  logic [63:0]                     time_ns,
  output logic                            read_valid,
  output logic [7:0]                      read_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ecr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ecr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ecr_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_REFRESH,
    S_READ,
    S_RESP
  } state_t;

  state_t state;
  ecr_cfg_t cfg;
  logic [ADDR_W-1:0] clr_cnt;
  logic [STEP_W-1:0] step;
  logic [1:0] noise;
  logic [ADDR_W-1:0] address;
  logic address_armed;
  logic [63:0] last_refresh_time;
  logic [1:0] cmd_q;
  logic [63:0] time_q;
  logic accept;
  logic refresh_due;
  logic [63:0] elapsed;
  ecr_wr_t refresh_wr;
  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0] ram_wdata;
  logic ram_re;
  logic [7:0] ram_rdata;

  ecr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  ecr_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(address),
    .rdata(ram_rdata)
  );

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign elapsed = time_q - last_refresh_time;
  assign refresh_due = (elapsed >= REFRESH_PERIOD_NS);
  assign refresh_wr = refresh_entry(step, cfg, noise);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = address;
    ram_wdata = data_value;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = reset_byte(clr_cnt);
      end
      S_REFRESH: begin
        ram_we = 1'b1;
        ram_waddr = refresh_wr.addr;
        ram_wdata = refresh_wr.data;
      end
      S_IDLE: begin
        ram_we = accept && (cmd == CMD_DATA_WRITE) && !address_armed;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign ram_re = ((state == S_CHECK) && !refresh_due) || (state == S_READ);
  assign read_valid = (state == S_RESP);
  assign read_data = ((cmd_q == CMD_STATUS_READ) || address_armed) ? 8'd0 : ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      step <= '0;
      noise <= '0;
      address <= '0;
      address_armed <= 1'b0;
      last_refresh_time <= '0;
      cmd_q <= CMD_DATA_READ;
      time_q <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(RAM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_q <= cmd;
            time_q <= time_ns;
            case (cmd)
              CMD_DATA_WRITE: begin
                if (address_armed) begin
                  address <= data_value;
                  address_armed <= 1'b0;
                end
              end
              CMD_COMMAND_WRITE: begin
                if ((data_value == OPC_RD_ARM) || (data_value == OPC_WR_ARM)) begin
                  address_armed <= 1'b1;
                end
              end
              default: state <= S_CHECK;
            endcase
          end
        end
        S_CHECK: begin
          if (refresh_due) begin
            last_refresh_time <= time_q;
            noise <= time_q[NOISE_LSB+1:NOISE_LSB];
            step <= '0;
            state <= S_REFRESH;
          end else begin
            state <= S_RESP;
          end
        end
        S_REFRESH: begin
          step <= step + 1'b1;
          if (step == STEP_W'(REFRESH_STEPS - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_RESP;
        S_RESP: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_resp_single: assert property (@(posedge clk) disable iff (rst)
    read_valid |=> !read_valid)
    else $error("Result strobe held for more than one cycle.");

  a_resp_while_busy: assert property (@(posedge clk) disable iff (rst)
    read_valid |-> busy && !accept)
    else $error("Result shown while a new transaction could be accepted.");

  a_no_write_at_resp: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |-> !ram_we)
    else $error("RAM written while a read result is shown.");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> busy && (state == S_CLEAR))
    else $error("Clearing pass not started after reset.");

endmodule
